### hdl/posht_pkg.sv
// Shared types and constants for the point-on-segment hit test unit.
// No dependencies; used by the top level and the checker.
package posht_pkg;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_START_X = 2'd0,
    REG_START_Y = 2'd1,
    REG_END_X   = 2'd2,
    REG_END_Y   = 2'd3
  } cfg_index_t;

  // Result stream width: the single on_segment bit padded to a byte.
  localparam int unsigned OUT_W = 8;

endpackage

### hdl/posht_dist_lane.sv
// Three-stage squared Euclidean distance lane: difference, square, sum.
// Standalone; its stage enables come from the top level's request chain.
module posht_dist_lane #(
  parameter int unsigned C = 12
) (
  input  logic           clk,
  input  logic [2:0]     en,
  input  logic [C-1:0]   ax,
  input  logic [C-1:0]   ay,
  input  logic [C-1:0]   bx,
  input  logic [C-1:0]   by,
  output logic [2*C:0]   dsq
);

  logic [C-1:0]   dx;
  logic [C-1:0]   dy;
  logic [2*C-1:0] sqx;
  logic [2*C-1:0] sqy;
  logic [2*C:0]   sum;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      dx <= (ax >= bx) ? ax - bx : bx - ax;
      dy <= (ay >= by) ? ay - by : by - ay;
    end
    if (en[1]) begin
      sqx <= (2*C)'(dx) * (2*C)'(dx);
      sqy <= (2*C)'(dy) * (2*C)'(dy);
    end
    if (en[2]) begin
      sum <= (2*C+1)'(sqx) + (2*C+1)'(sqy);
    end
  end

  assign dsq = sum;

endmodule

### hdl/posht_root_step.sv
// One pipeline stage of a digit-by-digit floor square root: one or two
// result bits per stage. Standalone; chained by the top level.
module posht_root_step #(
  parameter int unsigned RB    = 13,
  parameter int unsigned NSTEP = 2
) (
  input  logic               clk,
  input  logic               en,
  input  logic [2*RB-1:0]    rad_in,
  input  logic [RB+2:0]      rem_in,
  input  logic [RB-1:0]      root_in,
  output logic [2*RB-1:0]    rad_out,
  output logic [RB+2:0]      rem_out,
  output logic [RB-1:0]      root_out
);

  localparam int unsigned DW = 2 * RB;
  localparam int unsigned RW = RB + 3;

  logic [DW-1:0] rad;
  logic [RW-1:0] rem;
  logic [RB-1:0] root;
  logic [RW-1:0] sh;
  logic [RW-1:0] trial;

  always_comb begin
    rad   = rad_in;
    rem   = rem_in;
    root  = root_in;
    sh    = '0;
    trial = '0;
    for (int j = 0; j < NSTEP; j++) begin
      // Bring down the next two radicand bits and try (4 * root + 1).
      sh    = {rem[RW-3:0], rad[DW-1:DW-2]};
      rad   = {rad[DW-3:0], 2'b00};
      trial = {1'b0, root, 2'b01};
      if (sh >= trial) begin
        rem  = sh - trial;
        root = {root[RB-2:0], 1'b1};
      end else begin
        rem  = sh;
        root = {root[RB-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_out  <= rad;
      rem_out  <= rem;
      root_out <= root;
    end
  end

endmodule

### hdl/point_on_segment_hit_test_unit.sv
// Point-on-segment hit test: three distance lanes, pipelined square roots
// and a final compare. Depends on posht_pkg, posht_dist_lane, posht_root_step.
//
// The unit takes one query point per cycle unless the result side stalls,
// and returns one result per query, in order. Three stages form the squared
// distances, the square roots resolve up to two bits per stage, and a last
// stage compares the roots into the output register. A stall on the result
// side holds every occupied stage, while empty stages keep filling, so no
// request is dropped or repeated. The segment endpoints are written through
// the cfg port, which is always ready; write them only while no query is in
// flight.
module point_on_segment_hit_test_unit #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                         clk,
  input  logic                         rst,
  // s_axis_tdata, from bit 0: query_x, query_y, zero padding
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [((2*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
  // m_axis_tdata, from bit 0: on_segment, zero padding
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [posht_pkg::OUT_W-1:0]  m_axis_tdata,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [1:0]                   cfg_index,
  input  logic [COORD_BITS-1:0]        cfg_data
);

  localparam int unsigned C  = COORD_BITS;
  localparam int unsigned RB = C + 1;
  localparam int unsigned DW = 2 * RB;
  localparam int unsigned RW = RB + 3;
  localparam int unsigned NS = (RB + 1) / 2;
  localparam int unsigned P  = NS + 4;

  logic [C-1:0] seg_start_x;
  logic [C-1:0] seg_start_y;
  logic [C-1:0] seg_end_x;
  logic [C-1:0] seg_end_y;

  logic [P-1:0] vld;
  logic [P:0]   adv;

  logic [C-1:0] qx;
  logic [C-1:0] qy;
  logic [2*C:0] dsq [3];

  logic [DW-1:0] rad  [NS+1][3];
  logic [RW-1:0] rem  [NS+1][3];
  logic [RB-1:0] root [NS+1][3];

  logic on_segment;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      seg_start_x <= '0;
      seg_start_y <= '0;
      seg_end_x   <= '0;
      seg_end_y   <= '0;
    end else if (cfg_valid) begin
      unique case (posht_pkg::cfg_index_t'(cfg_index))
        posht_pkg::REG_START_X: seg_start_x <= cfg_data;
        posht_pkg::REG_START_Y: seg_start_y <= cfg_data;
        posht_pkg::REG_END_X:   seg_end_x   <= cfg_data;
        posht_pkg::REG_END_Y:   seg_end_y   <= cfg_data;
        default: ;
      endcase
    end
  end

  // A stage loads when it is empty or its contents move on.
  always_comb begin
    adv[P] = m_axis_tready;
    for (int i = P - 1; i >= 0; i--) begin
      adv[i] = !vld[i] || adv[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int i = 0; i < P; i++) begin
        if (adv[i]) begin
          vld[i] <= (i == 0) ? s_axis_tvalid : vld[(i == 0) ? 0 : i-1];
        end
      end
    end
  end

  assign s_axis_tready = adv[0];
  assign m_axis_tvalid = vld[P-1];

  assign qx = s_axis_tdata[C-1:0];
  assign qy = s_axis_tdata[2*C-1:C];

  posht_dist_lane #(.C(C)) u_dist_a (
    .clk(clk), .en(adv[2:0]),
    .ax(qx), .ay(qy), .bx(seg_start_x), .by(seg_start_y), .dsq(dsq[0])
  );

  posht_dist_lane #(.C(C)) u_dist_b (
    .clk(clk), .en(adv[2:0]),
    .ax(qx), .ay(qy), .bx(seg_end_x), .by(seg_end_y), .dsq(dsq[1])
  );

  posht_dist_lane #(.C(C)) u_dist_s (
    .clk(clk), .en(adv[2:0]),
    .ax(seg_start_x), .ay(seg_start_y), .bx(seg_end_x), .by(seg_end_y),
    .dsq(dsq[2])
  );

  for (genvar l = 0; l < 3; l++) begin : g_lane_in
    assign rad[0][l]  = {1'b0, dsq[l]};
    assign rem[0][l]  = '0;
    assign root[0][l] = '0;
  end

  for (genvar k = 0; k < NS; k++) begin : g_root
    localparam int unsigned NSTEP = (RB >= 2 * k + 2) ? 2 : 1;
    for (genvar l = 0; l < 3; l++) begin : g_lane
      posht_root_step #(.RB(RB), .NSTEP(NSTEP)) u_step (
        .clk     (clk),
        .en      (adv[3+k]),
        .rad_in  (rad[k][l]),
        .rem_in  (rem[k][l]),
        .root_in (root[k][l]),
        .rad_out (rad[k+1][l]),
        .rem_out (rem[k+1][l]),
        .root_out(root[k+1][l])
      );
    end
  end

  // The segment root must equal the sum of the two query roots.
  always_ff @(posedge clk) begin
    if (adv[P-1]) begin
      on_segment <= ({1'b0, root[NS][2]} ==
                     ({1'b0, root[NS][0]} + {1'b0, root[NS][1]}));
    end
  end

  assign m_axis_tdata = {{(posht_pkg::OUT_W-1){1'b0}}, on_segment};

endmodule

### hdl/posht_checker.sv
// Port-level checker for the point-on-segment hit test unit, with its bind.
// Depends on posht_pkg; sees only the top level's ports.
module posht_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         s_axis_tready,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [posht_pkg::OUT_W-1:0]  m_axis_tdata
);

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid straight after reset");

  // With the result side ready, nothing upstream may hold a request back.
  a_no_block: assert property (@(posedge clk) disable iff (rst)
    m_axis_tready |-> s_axis_tready)
    else $error("input stalled while output is ready");

  // A stalled result stays and keeps its value.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed or vanished");

  // Only the lowest bit of a result carries information.
  a_padding: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[posht_pkg::OUT_W-1:1] == '0)
    else $error("result padding bits not zero");

endmodule

bind point_on_segment_hit_test_unit posht_checker u_posht_checker (
  .clk(clk), .rst(rst),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata)
);
